[sv/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, field widths and codes of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    // defaults for the top-level parameters
    localparam int NUM_FRAMES_DEF = 4096;
    localparam int NUM_ORDERS_DEF = 11;

    // fixed field widths
    localparam int ACT_W  = 2;
    localparam int ORD_W  = 4;
    localparam int IDX_W  = 12;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 13;
    localparam int CIDX_W = 1;

    // frame word: kind above order
    localparam int KIND_W = 2;
    localparam int FRM_W  = KIND_W + ORD_W;

    // config reset values
    localparam logic [CFG_W-1:0] FIRST_RST = CFG_W'(1);
    localparam logic [CFG_W-1:0] END_RST   = CFG_W'(4096);

    // config register indexes
    localparam logic [CIDX_W-1:0] CFG_FIRST = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] CFG_END   = CIDX_W'(1);

    typedef enum logic [ACT_W-1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_INIT  = 2'd2,
        ACT_RSVD  = 2'd3
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_NOMEM = 2'd1,
        ST_ERR   = 2'd2
    } t_status;

    typedef enum logic [KIND_W-1:0] {
        KIND_USED = 2'd0,
        KIND_HEAD = 2'd1,
        KIND_TAIL = 2'd2
    } t_kind;

    typedef struct packed {
        logic [CFG_W-1:0] first_free_frame;
        logic [CFG_W-1:0] free_end_frame;
    } t_cfg;

endpackage

[sv/bpa_in_if.sv]
// ----------------------------------------------------------------------------
// bpa_in_if
// Request channel: action, requested order and page index.
// ----------------------------------------------------------------------------
interface bpa_in_if;
    import bpa_pkg::*;

    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [ORD_W-1:0] req_order;
    logic [IDX_W-1:0] page_index;

    modport source (output valid, output action, output req_order, output page_index,
                    input ready);
    modport sink   (input valid, input action, input req_order, input page_index,
                    output ready);
endinterface

[sv/bpa_out_if.sv]
// ----------------------------------------------------------------------------
// bpa_out_if
// Result channel: status, block index and block order.
// ----------------------------------------------------------------------------
interface bpa_out_if;
    import bpa_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  block_index;
    logic [ORD_W-1:0]  block_order;

    modport source (output valid, output status, output block_index, output block_order,
                    input ready);
    modport sink   (input valid, input status, input block_index, input block_order,
                    output ready);
endinterface

[sv/bpa_ram.sv]
// ----------------------------------------------------------------------------
// bpa_ram
// Simple dual-port synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/bpa_ctrl.sv]
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer of the allocator: init sweep, alloc split, free merge and
// the per-order free lists around the frame and link memories.
// ----------------------------------------------------------------------------
module bpa_ctrl import bpa_pkg::*; #(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int NUM_ORDERS = NUM_ORDERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    bpa_in_if.sink      i_in,
    bpa_out_if.source   o_out
);
    localparam int FW  = $clog2(NUM_FRAMES);
    localparam int SW  = ((FW + 1 > 16) ? FW + 1 : 16) + 1;
    localparam int CW  = FW + 1;
    localparam int OIW = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
    localparam logic [SW-1:0]    NF      = SW'(NUM_FRAMES);
    localparam logic [ORD_W-1:0] ORD_TOP = ORD_W'(NUM_ORDERS - 1);
    localparam logic [ORD_W:0]   ORD_NUM = (ORD_W + 1)'(NUM_ORDERS);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_SWEEP  = 14'b00000000000010,
        S_ISTART = 14'b00000000000100,
        S_ASCAN  = 14'b00000000001000,
        S_ASPLIT = 14'b00000000010000,
        S_FRD    = 14'b00000000100000,
        S_FCHK   = 14'b00000001000000,
        S_FLOOP  = 14'b00000010000000,
        S_FBUD   = 14'b00000100000000,
        S_FMRG   = 14'b00001000000000,
        S_FFIN   = 14'b00010000000000,
        S_REMRD  = 14'b00100000000000,
        S_REMUPD = 14'b01000000000000,
        S_DONE   = 14'b10000000000000
    } t_state;

    t_state r_state, n_state, r_ret, n_ret;
    logic            r_carve, n_carve;
    logic [SW-1:0]   r_i, n_i, r_bs, n_bs, r_lo, n_lo, r_hi, n_hi;
    logic [ORD_W-1:0] r_ord, n_ord, r_req, n_req, r_lord, n_lord;
    logic [IDX_W-1:0] r_pg, n_pg;
    logic [FW-1:0]   r_p, n_p, r_b, n_b, r_rm, n_rm;
    logic [FW-1:0]   r_head [NUM_ORDERS];
    logic [FW-1:0]   n_head [NUM_ORDERS];
    logic [FW-1:0]   r_tail [NUM_ORDERS];
    logic [FW-1:0]   n_tail [NUM_ORDERS];
    logic [CW-1:0]   r_cnt  [NUM_ORDERS];
    logic [CW-1:0]   n_cnt  [NUM_ORDERS];
    t_status         r_res_st, n_res_st;
    logic [IDX_W-1:0] r_res_idx, n_res_idx;
    logic [ORD_W-1:0] r_res_ord, n_res_ord;
    logic            r_out_valid, n_out_valid;
    t_status         r_out_st, n_out_st;
    logic [IDX_W-1:0] r_out_idx, n_out_idx;
    logic [ORD_W-1:0] r_out_ord, n_out_ord;

    // memory ports
    logic            fr_we, nx_we, pv_we;
    logic [FW-1:0]   fr_wa, fr_ra, nx_wa, pv_wa;
    logic [FRM_W-1:0] fr_wd, fr_rd;
    logic [FW-1:0]   nx_wd, pv_wd, nx_rd, pv_rd;

    // append request
    logic            app_en;
    logic [FW-1:0]   app_f;
    logic [ORD_W-1:0] app_o;

    // helpers
    logic [SW-1:0]   bx, sum;
    logic            in_rng;
    t_kind           rd_kind;
    logic [ORD_W-1:0] rd_ord;
    logic [SW-1:0]   cfg_lo, cfg_hi;

    assign rd_kind = t_kind'(fr_rd[FRM_W-1 -: KIND_W]);
    assign rd_ord  = fr_rd[ORD_W-1:0];
    assign cfg_lo  = (SW'(i_cfg.first_free_frame) > NF) ? NF : SW'(i_cfg.first_free_frame);
    assign cfg_hi  = (SW'(i_cfg.free_end_frame) > NF) ? NF : SW'(i_cfg.free_end_frame);

    bpa_ram #(.W(FRM_W), .DEPTH(NUM_FRAMES)) u_frame (
        .i_clk(i_clk), .i_we(fr_we), .i_waddr(fr_wa), .i_wdata(fr_wd),
        .i_raddr(fr_ra), .o_rdata(fr_rd)
    );
    bpa_ram #(.W(FW), .DEPTH(NUM_FRAMES)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_raddr(r_rm), .o_rdata(nx_rd)
    );
    bpa_ram #(.W(FW), .DEPTH(NUM_FRAMES)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_wa), .i_wdata(pv_wd),
        .i_raddr(r_rm), .o_rdata(pv_rd)
    );

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_st;
    assign o_out.block_index = r_out_idx;
    assign o_out.block_order = r_out_ord;

    // next-state logic
    always_comb begin
        n_state = r_state;  n_ret = r_ret;  n_carve = r_carve;
        n_i = r_i;  n_bs = r_bs;  n_lo = r_lo;  n_hi = r_hi;
        n_ord = r_ord;  n_req = r_req;  n_lord = r_lord;  n_pg = r_pg;
        n_p = r_p;  n_b = r_b;  n_rm = r_rm;
        n_head = r_head;  n_tail = r_tail;  n_cnt = r_cnt;
        n_res_st = r_res_st;  n_res_idx = r_res_idx;  n_res_ord = r_res_ord;
        n_out_valid = r_out_valid;  n_out_st = r_out_st;
        n_out_idx = r_out_idx;  n_out_ord = r_out_ord;
        fr_we = 1'b0;  fr_wa = '0;  fr_wd = '0;  fr_ra = '0;
        nx_we = 1'b0;  nx_wa = '0;  nx_wd = '0;
        pv_we = 1'b0;  pv_wa = '0;  pv_wd = '0;
        app_en = 1'b0;  app_f = '0;  app_o = '0;
        bx = '0;  sum = '0;  in_rng = 1'b0;

        // result beat leaves
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_req = i_in.req_order;
                    n_pg  = i_in.page_index;
                    n_res_st = ST_ERR;  n_res_idx = '0;  n_res_ord = '0;
                    unique case (t_action'(i_in.action))
                        ACT_ALLOC: begin
                            if ({1'b0, i_in.req_order} >= ORD_NUM) begin
                                n_state = S_DONE;
                            end else begin
                                n_ord   = i_in.req_order;
                                n_state = S_ASCAN;
                            end
                        end
                        ACT_FREE: n_state = S_FRD;
                        ACT_INIT: begin
                            n_res_st = ST_OK;
                            n_state  = S_ISTART;
                        end
                        ACT_RSVD: n_state = S_DONE;
                    endcase
                end
            end
            S_ISTART: begin
                for (int k = 0; k < NUM_ORDERS; k++) n_cnt[k] = '0;
                n_lo = cfg_lo;  n_hi = cfg_hi;
                n_i = '0;  n_bs = cfg_lo;  n_ord = ORD_TOP;
                n_carve = 1'b1;
                n_state = S_SWEEP;
            end
            // one frame per cycle, heads wait while the order shrinks
            S_SWEEP: begin
                if (r_i == NF) begin
                    n_state = r_carve ? S_DONE : S_IDLE;
                end else begin
                    in_rng = r_carve && (r_i >= r_lo) && (r_i < r_hi);
                    sum    = r_i + (SW'(1) << r_ord);
                    fr_wa  = FW'(r_i);
                    if (in_rng && r_i == r_bs) begin
                        if (r_ord != '0 && sum > r_hi) begin
                            n_ord = r_ord - 1'b1;
                        end else begin
                            fr_we  = 1'b1;
                            fr_wd  = {KIND_HEAD, r_ord};
                            app_en = 1'b1;  app_f = FW'(r_i);  app_o = r_ord;
                            n_bs   = sum;
                            n_i    = r_i + 1'b1;
                        end
                    end else begin
                        fr_we = 1'b1;
                        fr_wd = in_rng ? {KIND_TAIL, ORD_W'(0)} : {KIND_USED, ORD_W'(0)};
                        n_i   = r_i + 1'b1;
                    end
                end
            end
            // find the lowest non-empty list at or above the request
            S_ASCAN: begin
                if (r_cnt[r_ord[OIW-1:0]] != '0) begin
                    n_p    = r_head[r_ord[OIW-1:0]];
                    n_rm   = r_head[r_ord[OIW-1:0]];
                    n_lord = r_ord;
                    n_ret  = S_ASPLIT;
                    n_state = S_REMRD;
                end else if (r_ord == ORD_TOP) begin
                    n_res_st = ST_NOMEM;
                    n_state  = S_DONE;
                end else begin
                    n_ord = r_ord + 1'b1;
                end
            end
            // hand the upper half back, one order per cycle
            S_ASPLIT: begin
                if (r_ord == r_req) begin
                    fr_we = 1'b1;  fr_wa = r_p;  fr_wd = {KIND_USED, r_req};
                    n_res_st = ST_OK;  n_res_idx = IDX_W'(r_p);  n_res_ord = r_req;
                    n_state = S_DONE;
                end else begin
                    bx    = SW'(r_p) + (SW'(1) << (r_ord - 1'b1));
                    n_ord = r_ord - 1'b1;
                    if (bx < NF) begin
                        fr_we  = 1'b1;  fr_wa = FW'(bx);
                        fr_wd  = {KIND_HEAD, ORD_W'(r_ord - 1'b1)};
                        app_en = 1'b1;  app_f = FW'(bx);  app_o = r_ord - 1'b1;
                    end
                end
            end
            S_FRD: begin
                if (SW'(r_pg) >= NF) begin
                    n_res_idx = r_pg;
                    n_state   = S_DONE;
                end else begin
                    fr_ra   = FW'(SW'(r_pg));
                    n_p     = FW'(SW'(r_pg));
                    n_state = S_FCHK;
                end
            end
            S_FCHK: begin
                if (rd_kind != KIND_USED) begin
                    n_res_idx = r_pg;
                    n_state   = S_DONE;
                end else begin
                    n_ord   = (rd_ord > ORD_TOP) ? ORD_TOP : rd_ord;
                    n_state = S_FLOOP;
                end
            end
            S_FLOOP: begin
                bx = SW'(r_p) ^ (SW'(1) << r_ord);
                if (r_ord >= ORD_TOP || bx >= NF) begin
                    n_state = S_FFIN;
                end else begin
                    fr_ra   = FW'(bx);
                    n_b     = FW'(bx);
                    n_state = S_FBUD;
                end
            end
            S_FBUD: begin
                if (rd_kind != KIND_HEAD || rd_ord != r_ord) begin
                    n_state = S_FFIN;
                end else begin
                    n_rm   = r_b;
                    n_lord = r_ord;
                    n_ret  = S_FMRG;
                    n_state = S_REMRD;
                end
            end
            // upper buddy becomes a tail, lower one is the new head
            S_FMRG: begin
                fr_we = 1'b1;
                fr_wd = {KIND_TAIL, r_ord};
                if (r_b > r_p) begin
                    fr_wa = r_b;
                end else begin
                    fr_wa = r_p;
                    n_p   = r_b;
                end
                n_ord   = r_ord + 1'b1;
                n_state = S_FLOOP;
            end
            S_FFIN: begin
                fr_we  = 1'b1;  fr_wa = r_p;  fr_wd = {KIND_HEAD, r_ord};
                app_en = 1'b1;  app_f = r_p;  app_o = r_ord;
                n_res_st = ST_OK;  n_res_idx = IDX_W'(r_p);  n_res_ord = r_ord;
                n_state = S_DONE;
            end
            // list removal: read links, then relink neighbors
            S_REMRD: begin
                if (r_cnt[r_lord[OIW-1:0]] == '0) begin
                    n_state = r_ret;
                end else if (r_cnt[r_lord[OIW-1:0]] == CW'(1)) begin
                    n_cnt[r_lord[OIW-1:0]] = '0;
                    n_state = r_ret;
                end else begin
                    n_state = S_REMUPD;
                end
            end
            S_REMUPD: begin
                if (r_rm == r_head[r_lord[OIW-1:0]]) begin
                    n_head[r_lord[OIW-1:0]] = nx_rd;
                end else begin
                    nx_we = 1'b1;  nx_wa = pv_rd;  nx_wd = nx_rd;
                end
                if (r_rm == r_tail[r_lord[OIW-1:0]]) begin
                    n_tail[r_lord[OIW-1:0]] = pv_rd;
                end else begin
                    pv_we = 1'b1;  pv_wa = nx_rd;  pv_wd = pv_rd;
                end
                n_cnt[r_lord[OIW-1:0]] = r_cnt[r_lord[OIW-1:0]] - 1'b1;
                n_state = r_ret;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_st  = r_res_st;
                    n_out_idx = r_res_idx;
                    n_out_ord = r_res_ord;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // append to the tail of a list
        if (app_en) begin
            if (r_cnt[app_o[OIW-1:0]] == '0) begin
                n_head[app_o[OIW-1:0]] = app_f;
            end else begin
                nx_we = 1'b1;  nx_wa = r_tail[app_o[OIW-1:0]];  nx_wd = app_f;
                pv_we = 1'b1;  pv_wa = app_f;  pv_wd = r_tail[app_o[OIW-1:0]];
            end
            n_tail[app_o[OIW-1:0]] = app_f;
            n_cnt[app_o[OIW-1:0]]  = r_cnt[app_o[OIW-1:0]] + 1'b1;
        end
    end

    // control registers, reset starts the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_ret       <= S_IDLE;
            r_carve     <= 1'b0;
            r_i         <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_ORDERS; k++) r_cnt[k] <= '0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_carve     <= n_carve;
            r_i         <= n_i;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_bs <= n_bs;  r_lo <= n_lo;  r_hi <= n_hi;
        r_ord <= n_ord;  r_req <= n_req;  r_lord <= n_lord;  r_pg <= n_pg;
        r_p <= n_p;  r_b <= n_b;  r_rm <= n_rm;
        r_head <= n_head;  r_tail <= n_tail;
        r_res_st <= n_res_st;  r_res_idx <= n_res_idx;  r_res_ord <= n_res_ord;
        r_out_st <= n_out_st;  r_out_idx <= n_out_idx;  r_out_ord <= n_out_ord;
    end
endmodule

[sv/buddy_page_allocator.sv]
// An alloc scans the free lists, removes a block and splits it down to the
// requested order; a free checks the page and merges it with each free buddy;
// an init sweeps all frames. One item is in work at a time; the sequencer
// around the frame memory, one read and one write a cycle, sets the rate. A
// result waits in an output register while the next item is accepted. Reset
// runs a clearing sweep over all frames; no item is accepted until it ends.
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy page-frame allocator with per-order FIFO free lists.
// ----------------------------------------------------------------------------
module buddy_page_allocator import bpa_pkg::*; #(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int NUM_ORDERS = NUM_ORDERS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    bpa_in_if.sink            i_in,
    bpa_out_if.source         o_out
);
    t_cfg r_cfg;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_free_frame <= FIRST_RST;
            r_cfg.free_end_frame   <= END_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_FIRST) begin
                r_cfg.first_free_frame <= i_cfg_data;
            end
            if (i_cfg_idx == CFG_END) begin
                r_cfg.free_end_frame <= i_cfg_data;
            end
        end
    end

    bpa_ctrl #(.NUM_FRAMES(NUM_FRAMES), .NUM_ORDERS(NUM_ORDERS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_in(i_in), .o_out(o_out)
    );
endmodule
